// ===== hw/rtl/wsfr_pkg.sv =====
package wsfr_pkg;

  localparam logic [7:0] FRAME_SEED = 8'h80;
  localparam logic [7:0] CMD_SERVO  = 8'h04;
  localparam logic [7:0] CMD_NORMAL = 8'h07;
  localparam logic [7:0] CMD_RESET  = 8'h7F;
  localparam logic [7:0] SERVO_BIAS = 8'h80;

  localparam int unsigned QUEUE_DEPTH = 2;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic       accepted;
    logic       dropped;
    logic [7:0] cmd;
    logic [7:0] servo_pos;
  } wsfr_rec_t;

endpackage

// ===== hw/rtl/wsfr_in_if.sv =====
interface wsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/wsfr_out_if.sv =====
interface wsfr_out_if;
  logic              valid;
  logic              ready;
  logic              frame_accepted;
  logic              byte_dropped;
  logic [7:0]        command_code;
  logic signed [7:0] servo_target;
  logic              initializing;

  modport source (output valid, output frame_accepted, output byte_dropped,
                  output command_code, output servo_target, output initializing,
                  input ready);
  modport sink (input valid, input frame_accepted, input byte_dropped,
                input command_code, input servo_target, input initializing,
                output ready);
endinterface

// ===== hw/rtl/wsfr_front.sv =====
module wsfr_front (
  input  logic                clk,
  input  logic                rst_n,
  wsfr_in_if.sink             in_ch,
  input  logic                q_full,
  output logic                push,
  output wsfr_pkg::wsfr_rec_t rec
);
  import wsfr_pkg::*;

  localparam logic [1:0] FILL_FULL = 2'd3;

  logic [7:0] win_r [3];
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic [7:0] chk;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    chk = FRAME_SEED ^ win_r[0] ^ win_r[1] ^ win_r[2] ^ in_ch.rx_byte;
    rec = '0;
    // bit 7 of the position is byte1 bit0 or'ed with byte2 bit7
    rec.servo_pos = {win_r[1][0] | win_r[2][7], win_r[2][6:0]};
    fill_nxt = fill_r;
    if (fill_r != FILL_FULL) begin
      fill_nxt = fill_r + 2'd1;
    end else if (chk == 8'h00) begin
      rec.accepted = 1'b1;
      rec.cmd      = win_r[0] ^ FRAME_SEED;
      fill_nxt     = 2'd0;
    end else begin
      rec.dropped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else if (push) begin
      fill_r <= fill_nxt;
    end
  end

  // window bytes are only read once the fill count says they were written
  always_ff @(posedge clk) begin
    if (push) begin
      if (fill_r != FILL_FULL) begin
        win_r[fill_r] <= in_ch.rx_byte;
      end else if (!rec.accepted) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= in_ch.rx_byte;
      end
    end
  end

endmodule

// ===== hw/rtl/wsfr_queue.sv =====
module wsfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsfr_pkg::wsfr_rec_t push_rec,
  output logic                full,
  output logic                q_valid,
  input  logic                pop,
  output wsfr_pkg::wsfr_rec_t pop_rec
);
  import wsfr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  wsfr_rec_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == FULL_CNT);
  assign q_valid = (count_r != '0);
  assign pop_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not grow on push");

  a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("queue count did not shrink on pop");

endmodule

// ===== hw/rtl/wsfr_back.sv =====
module wsfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  wsfr_pkg::wsfr_rec_t rec,
  output logic                pop,
  wsfr_out_if.source          out_ch
);
  import wsfr_pkg::*;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_INIT    = 2'd1,
    MODE_NORMAL  = 2'd2
  } wheel_mode_t;

  wheel_mode_t       mode_r;
  wheel_mode_t       mode_nxt;
  logic [7:0]        servo_r;
  logic [7:0]        servo_nxt;
  logic              out_valid_r;
  logic              acc_r;
  logic              drop_r;
  logic [7:0]        cmd_r;
  logic              init_r;

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    mode_nxt  = mode_r;
    servo_nxt = servo_r;
    if (rec.accepted) begin
      unique case (rec.cmd)
        CMD_SERVO:  servo_nxt = SERVO_BIAS - rec.servo_pos;
        CMD_NORMAL: mode_nxt  = MODE_NORMAL;
        CMD_RESET:  mode_nxt  = MODE_INIT;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_UNKNOWN;
      servo_r     <= 8'h00;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      mode_r      <= mode_nxt;
      servo_r     <= servo_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc_r  <= rec.accepted;
      drop_r <= rec.dropped;
      cmd_r  <= rec.cmd;
      init_r <= (mode_nxt == MODE_INIT);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_accepted = acc_r;
  assign out_ch.byte_dropped   = drop_r;
  assign out_ch.command_code   = cmd_r;
  assign out_ch.servo_target   = servo_r;
  assign out_ch.initializing   = init_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(acc_r && drop_r))
    else $error("item both accepted and dropped");

  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !acc_r) |-> (cmd_r == 8'h00))
    else $error("command code set on a frame not accepted");

  a_reset_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && rec.accepted && rec.cmd == CMD_RESET) |=> (init_r && mode_r == MODE_INIT))
    else $error("reset command did not enter initializing mode");

endmodule

// ===== hw/rtl/wheel_serial_frame_receiver_core.sv =====
// path: a result passes the combinational front, a queue entry and the output register in the back
// throughput: one byte per cycle unless the queue is full, set by the combinational window check in
//   the front and the one-entry output register in the back; a two-entry queue lets either side stall alone
// reset (rst_n low, synchronous): window emptied, mode unknown, servo position zero,
//   queue and output register empty
module wheel_serial_frame_receiver_core (
  input logic      clk,
  input logic      rst_n,
  wsfr_in_if.sink  in_ch,
  wsfr_out_if.source out_ch
);
  import wsfr_pkg::*;

  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      pop;
  wsfr_rec_t push_rec;
  wsfr_rec_t pop_rec;

  wsfr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .rec    (push_rec)
  );

  wsfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_rec  (pop_rec)
  );

  wsfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .rec     (pop_rec),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== sim/tb_wheel_serial_frame_receiver_core.sv =====
`timescale 1ns / 100ps

module tb_wheel_serial_frame_receiver_core;
  import wsfr_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RANDOM_BYTES = 600;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_INIT    = 2'd1,
    MODE_NORMAL  = 2'd2
  } wheel_mode_t;

  typedef struct packed {
    logic       accepted;
    logic       dropped;
    logic [7:0] cmd;
    logic [7:0] servo;
    logic       init;
  } wheel_reply_t;

  typedef struct packed {
    logic [7:0]   rx;
    logic         typed;
    wheel_reply_t reply;
  } stim_row_t;

  logic clk;
  logic rst_n;

  wsfr_in_if  in_ch ();
  wsfr_out_if out_ch ();

  wheel_serial_frame_receiver_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [7:0]  win_bytes [3];
  logic [1:0]  win_fill;
  wheel_mode_t wheel_mode;
  logic [7:0]  servo_pos;

  wheel_reply_t reply_q[$];
  stim_row_t    stim_rows[$];
  int unsigned  mismatches;
  int unsigned  cycles;
  int unsigned  random_sent;
  logic         steady;
  logic         hold_req;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic wheel_reply_t decode_byte(input logic [7:0] b);
    wheel_reply_t r;
    logic [7:0]   sum;
    logic [7:0]   pos;
    r = '0;
    if (win_fill < 2'd3) begin
      win_bytes[win_fill] = b;
      win_fill = win_fill + 2'd1;
    end else begin
      sum = FRAME_SEED ^ win_bytes[0] ^ win_bytes[1] ^ win_bytes[2] ^ b;
      if (sum == 8'h00) begin
        r.accepted = 1'b1;
        r.cmd = win_bytes[0] ^ FRAME_SEED;
        if (r.cmd == CMD_SERVO) begin
          pos = {win_bytes[1][0], 7'b0} | win_bytes[2];
          servo_pos = SERVO_BIAS - pos;
        end else if (r.cmd == CMD_NORMAL) begin
          wheel_mode = MODE_NORMAL;
        end else if (r.cmd == CMD_RESET) begin
          wheel_mode = MODE_INIT;
        end
        win_fill = 2'd0;
      end else begin
        // slide by one byte to resync
        win_bytes[0] = win_bytes[1];
        win_bytes[1] = win_bytes[2];
        win_bytes[2] = b;
        r.dropped = 1'b1;
      end
    end
    r.servo = servo_pos;
    r.init = (wheel_mode == MODE_INIT);
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input wheel_reply_t fixed);
    wheel_reply_t predicted;
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = decode_byte(b);
    reply_q.push_back(typed ? fixed : predicted);
    random_sent = random_sent + 1;
  endtask

  // last byte closes the xor check unless corrupted
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] corrupt);
    logic [7:0] f0;
    logic [7:0] f1;
    logic [7:0] f2;
    f0 = cmd ^ FRAME_SEED;
    f1 = 8'($urandom_range(0, 255));
    f2 = 8'($urandom_range(0, 255));
    send_byte(f0, 1'b0, '0);
    send_byte(f1, 1'b0, '0);
    send_byte(f2, 1'b0, '0);
    send_byte(FRAME_SEED ^ f0 ^ f1 ^ f2 ^ corrupt, 1'b0, '0);
  endtask

  function automatic void add_row(input logic [7:0] rx, input logic typed, input logic acc,
                                  input logic drop, input logic [7:0] cmd,
                                  input logic [7:0] servo, input logic init);
    stim_row_t row;
    row.rx = rx;
    row.typed = typed;
    row.reply = '{accepted: acc, dropped: drop, cmd: cmd, servo: servo, init: init};
    stim_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches = mismatches + 1;
    end
  endfunction

  // result side
  initial begin
    int unsigned  stall_left;
    wheel_reply_t exp_r;
    logic         hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (reply_q.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatches = mismatches + 1;
        end else begin
          exp_r = reply_q.pop_front();
          check_field("frame_accepted", 8'(exp_r.accepted), 8'(out_ch.frame_accepted));
          check_field("byte_dropped", 8'(exp_r.dropped), 8'(out_ch.byte_dropped));
          check_field("command_code", exp_r.cmd, out_ch.command_code);
          check_field("servo_target", exp_r.servo, $unsigned(out_ch.servo_target));
          check_field("initializing", 8'(exp_r.init), 8'(out_ch.initializing));
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // input side
  initial begin
    int unsigned pick;
    int unsigned sel;
    logic [7:0]  cmd;
    logic        hold_done;

    win_bytes = '{8'h00, 8'h00, 8'h00};
    win_fill = 2'd0;
    wheel_mode = MODE_UNKNOWN;
    servo_pos = 8'h00;
    mismatches = 0;
    cycles = 0;
    random_sent = 0;
    hold_done = 1'b0;
    steady <= 1'b0;
    hold_req <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // filling after reset, then a frame with an unhandled command
    add_row(8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h7F, 1'b1, 1'b1, 1'b0, 8'h80, 8'h00, 1'b0);
    // reset command enters initializing mode
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h7F, 1'b1, 1'b1, 1'b0, CMD_RESET, 8'h00, 1'b1);
    // normal command leaves it
    add_row(8'h87, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h07, 1'b1, 1'b1, 1'b0, CMD_NORMAL, 8'h00, 1'b0);
    // servo, largest position
    add_row(8'h84, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'hFA, 1'b1, 1'b1, 1'b0, CMD_SERVO, 8'h81, 1'b0);
    // servo, position zero
    add_row(8'h84, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h04, 1'b1, 1'b1, 1'b0, CMD_SERVO, 8'h80, 1'b0);
    // failed check drops a byte, next byte completes a frame
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    add_row(8'h00, 1'b1, 1'b0, 1'b1, 8'h00, 8'h80, 1'b0);
    add_row(8'h80, 1'b1, 1'b1, 1'b0, 8'h80, 8'h80, 1'b0);

    foreach (stim_rows[i]) send_byte(stim_rows[i].rx, stim_rows[i].typed, stim_rows[i].reply);

    // sender pauses until everything is back
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);

    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      if (!hold_done && random_sent >= 150) begin
        hold_req <= 1'b1;
        hold_done = 1'b1;
      end
      steady <= (random_sent >= 300 && random_sent < 400);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        sel = $urandom_range(0, 9);
        if (sel < 3) cmd = CMD_SERVO;
        else if (sel < 5) cmd = CMD_NORMAL;
        else if (sel < 7) cmd = CMD_RESET;
        else cmd = 8'($urandom_range(0, 255));
        send_frame(cmd, 8'h00);
      end else if (pick < 90) begin
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== wheel_serial_frame_receiver_core.f =====
hw/rtl/wsfr_pkg.sv
hw/rtl/wsfr_in_if.sv
hw/rtl/wsfr_out_if.sv
hw/rtl/wsfr_front.sv
hw/rtl/wsfr_queue.sv
hw/rtl/wsfr_back.sv
hw/rtl/wheel_serial_frame_receiver_core.sv
sim/tb_wheel_serial_frame_receiver_core.sv
